>>> sv/tkd_pkg.sv
// shared types, codes and constants of the terminal key decoder
package tkd_pkg;

   // decoder modes
   localparam logic [1:0] ModeGround = 2'd0;
   localparam logic [1:0] ModeEscape = 2'd1;
   localparam logic [1:0] ModeCsi    = 2'd2;
   localparam logic [1:0] ModeUtf8   = 2'd3;

   // key codes
   localparam logic [3:0] KeyChar  = 4'd0;
   localparam logic [3:0] KeyEsc   = 4'd1;
   localparam logic [3:0] KeyIntr  = 4'd2;
   localparam logic [3:0] KeyBksp  = 4'd3;
   localparam logic [3:0] KeyEnter = 4'd4;
   localparam logic [3:0] KeyTab   = 4'd5;
   localparam logic [3:0] KeyHome  = 4'd6;
   localparam logic [3:0] KeyEnd   = 4'd7;
   localparam logic [3:0] KeyLeft  = 4'd8;
   localparam logic [3:0] KeyRight = 4'd9;
   localparam logic [3:0] KeyUp    = 4'd10;
   localparam logic [3:0] KeyDown  = 4'd11;
   localparam logic [3:0] KeyDel   = 4'd12;
   localparam logic [3:0] KeyPgUp  = 4'd13;
   localparam logic [3:0] KeyPgDn  = 4'd14;

   // item kinds
   localparam logic KindByte    = 1'b0;
   localparam logic KindTimeout = 1'b1;

   // byte codes
   localparam logic [7:0] ByteEsc      = 8'h1B;
   localparam logic [7:0] ByteEtx      = 8'h03;
   localparam logic [7:0] ByteDel      = 8'h7F;
   localparam logic [7:0] ByteBs       = 8'h08;
   localparam logic [7:0] ByteCr       = 8'h0D;
   localparam logic [7:0] ByteLf       = 8'h0A;
   localparam logic [7:0] ByteTab      = 8'h09;
   localparam logic [7:0] ByteSoh      = 8'h01;
   localparam logic [7:0] ByteEnq      = 8'h05;
   localparam logic [7:0] ByteBracket  = 8'h5B;
   localparam logic [7:0] ByteFinalLo  = 8'h40;
   localparam logic [7:0] ByteFinalHi  = 8'h7E;
   localparam logic [7:0] ByteSpace    = 8'h20;
   localparam logic [7:0] ByteAsciiTop = 8'h7F;
   localparam logic [7:0] FinalUp      = 8'h41;
   localparam logic [7:0] FinalDown    = 8'h42;
   localparam logic [7:0] FinalRight   = 8'h43;
   localparam logic [7:0] FinalLeft    = 8'h44;
   localparam logic [7:0] FinalEnd     = 8'h46;
   localparam logic [7:0] FinalHome    = 8'h48;
   localparam logic [7:0] FinalTilde   = 8'h7E;
   localparam logic [7:0] ParamHome    = 8'h31;
   localparam logic [7:0] ParamDel     = 8'h33;
   localparam logic [7:0] ParamEnd     = 8'h34;
   localparam logic [7:0] ParamPgUp    = 8'h35;
   localparam logic [7:0] ParamPgDn    = 8'h36;

   // parameter count saturates here
   localparam logic [1:0] ParamCountMax = 2'd3;

   // output queue geometry
   localparam int QueueDepth   = 4;
   localparam int QueuePtrBits = $clog2(QueueDepth);
   localparam int QueueCntBits = $clog2(QueueDepth + 1);
   // the decoder can push two results in one cycle
   localparam int QueueRoomNeeded = 2;

   // one result item
   typedef struct packed {
      logic [3:0]  key;
      logic [31:0] text_bytes;
      logic [2:0]  text_length;
      logic        last;
   } tkd_result_type;

   // decoder state
   typedef struct packed {
      logic [1:0]  mode;
      logic [23:0] utf8_gathered;
      logic [2:0]  utf8_expected;
      logic [2:0]  utf8_count;
      logic [7:0]  param_first;
      logic [1:0]  param_count;
   } tkd_state_type;

   // results of one decoded item, first one in res_first
   typedef struct packed {
      logic [1:0]     count;
      tkd_result_type res_first;
      tkd_result_type res_second;
   } tkd_push_type;

   // output queue status toward the top level
   typedef struct packed {
      logic [QueueCntBits-1:0] count;
      logic                    has_room;
   } tkd_queue_status_type;

endpackage

>>> sv/tkd_stream_if.sv
// valid/ready channels for input items and result items
interface tkd_req_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] byte_value;

   modport source (output valid, output kind, output byte_value, input ready);
   modport sink   (input valid, input kind, input byte_value, output ready);
endinterface

interface tkd_rsp_if;
   logic        valid;
   logic        ready;
   logic [3:0]  key;
   logic [31:0] text_bytes;
   logic [2:0]  text_length;
   logic        last;

   modport source (output valid, output key, output text_bytes, output text_length,
                   output last, input ready);
   modport sink   (input valid, input key, input text_bytes, input text_length,
                   input last, output ready);
endinterface

>>> sv/tkd_decode.sv
// next-state and result logic for one input item
module tkd_decode (
   input  tkd_pkg::tkd_state_type state,
   input  logic                   kind,
   input  logic [7:0]             byte_value,
   output tkd_pkg::tkd_state_type state_next,
   output tkd_pkg::tkd_push_type  push
);

   typedef struct packed {
      logic       emit;
      logic [3:0] key;
      logic [7:0] text;
      logic [2:0] len;
      logic       go_escape;
      logic       go_utf8;
      logic [2:0] lead_len;
   } ground_type;

   typedef struct packed {
      logic       hit;
      logic [3:0] key;
   } csi_type;

   // plain ground handling of one byte
   function automatic ground_type ground_byte(input logic [7:0] b);
      ground_type g;
      g = '0;
      if (b == tkd_pkg::ByteEsc) begin
         g.go_escape = 1'b1;
      end else if (b == tkd_pkg::ByteEtx) begin
         g.emit = 1'b1;
         g.key  = tkd_pkg::KeyIntr;
      end else if (b == tkd_pkg::ByteDel || b == tkd_pkg::ByteBs) begin
         g.emit = 1'b1;
         g.key  = tkd_pkg::KeyBksp;
      end else if (b == tkd_pkg::ByteCr || b == tkd_pkg::ByteLf) begin
         g.emit = 1'b1;
         g.key  = tkd_pkg::KeyEnter;
      end else if (b == tkd_pkg::ByteTab) begin
         g.emit = 1'b1;
         g.key  = tkd_pkg::KeyTab;
      end else if (b == tkd_pkg::ByteSoh) begin
         g.emit = 1'b1;
         g.key  = tkd_pkg::KeyHome;
      end else if (b == tkd_pkg::ByteEnq) begin
         g.emit = 1'b1;
         g.key  = tkd_pkg::KeyEnd;
      end else if (b < tkd_pkg::ByteSpace) begin
         g.emit = 1'b0;
      end else if (b inside {[tkd_pkg::ByteSpace:tkd_pkg::ByteAsciiTop]}) begin
         g.emit = 1'b1;
         g.key  = tkd_pkg::KeyChar;
         g.text = b;
         g.len  = 3'd1;
      end else if (b[7:5] == 3'b110) begin
         g.go_utf8  = 1'b1;
         g.lead_len = 3'd2;
      end else if (b[7:4] == 4'b1110) begin
         g.go_utf8  = 1'b1;
         g.lead_len = 3'd3;
      end else if (b[7:3] == 5'b11110) begin
         g.go_utf8  = 1'b1;
         g.lead_len = 3'd4;
      end
      return g;
   endfunction

   // final byte of a csi sequence to key
   function automatic csi_type csi_key(input logic [7:0] fin, input logic [7:0] pfirst,
                                       input logic [1:0] pcount);
      csi_type c;
      c.hit = 1'b1;
      c.key = tkd_pkg::KeyChar;
      case (fin)
         tkd_pkg::FinalLeft:  c.key = tkd_pkg::KeyLeft;
         tkd_pkg::FinalRight: c.key = tkd_pkg::KeyRight;
         tkd_pkg::FinalHome:  c.key = tkd_pkg::KeyHome;
         tkd_pkg::FinalEnd:   c.key = tkd_pkg::KeyEnd;
         tkd_pkg::FinalUp:    c.key = tkd_pkg::KeyUp;
         tkd_pkg::FinalDown:  c.key = tkd_pkg::KeyDown;
         tkd_pkg::FinalTilde: begin
            if (pcount != 2'd1) begin
               c.hit = 1'b0;
            end else begin
               case (pfirst)
                  tkd_pkg::ParamHome: c.key = tkd_pkg::KeyHome;
                  tkd_pkg::ParamEnd:  c.key = tkd_pkg::KeyEnd;
                  tkd_pkg::ParamDel:  c.key = tkd_pkg::KeyDel;
                  tkd_pkg::ParamPgUp: c.key = tkd_pkg::KeyPgUp;
                  tkd_pkg::ParamPgDn: c.key = tkd_pkg::KeyPgDn;
                  default:            c.hit = 1'b0;
               endcase
            end
         end
         default: c.hit = 1'b0;
      endcase
      return c;
   endfunction

   ground_type              g;
   csi_type                 c;
   logic                    run_ground;
   logic                    emit_esc;
   logic                    emit_main;
   tkd_pkg::tkd_result_type main_res;
   tkd_pkg::tkd_result_type esc_res;
   logic [1:0]              cnt;
   logic [2:0]              cnt_inc;
   logic [31:0]             utf8_text;

   // ground handling, csi lookup and utf8 gather for the current byte
   always_comb begin
      g         = ground_byte(byte_value);
      c         = csi_key(byte_value, state.param_first, state.param_count);
      cnt       = state.utf8_count[1:0];
      cnt_inc   = {1'b0, cnt} + 3'd1;
      utf8_text = {8'd0, state.utf8_gathered} | ({24'd0, byte_value} << {cnt, 3'b000});
   end

   // mode transitions and result selection
   always_comb begin
      state_next = state;
      run_ground = 1'b0;
      emit_esc   = 1'b0;
      emit_main  = 1'b0;
      main_res   = '0;
      esc_res    = '0;
      esc_res.key = tkd_pkg::KeyEsc;

      if (kind == tkd_pkg::KindTimeout) begin
         if (state.mode == tkd_pkg::ModeEscape) begin
            emit_esc        = 1'b1;
            state_next.mode = tkd_pkg::ModeGround;
         end
      end else begin
         case (state.mode)
            tkd_pkg::ModeGround: begin
               run_ground = 1'b1;
            end
            tkd_pkg::ModeEscape: begin
               if (byte_value == tkd_pkg::ByteBracket) begin
                  state_next.mode        = tkd_pkg::ModeCsi;
                  state_next.param_first = '0;
                  state_next.param_count = '0;
               end else begin
                  state_next.mode = tkd_pkg::ModeGround;
                  emit_esc        = 1'b1;
                  run_ground      = 1'b1;
               end
            end
            tkd_pkg::ModeCsi: begin
               if (byte_value inside {[tkd_pkg::ByteFinalLo:tkd_pkg::ByteFinalHi]}) begin
                  emit_main              = c.hit;
                  main_res.key           = c.key;
                  state_next.mode        = tkd_pkg::ModeGround;
                  state_next.param_first = '0;
                  state_next.param_count = '0;
               end else begin
                  if (state.param_count == 2'd0) begin
                     state_next.param_first = byte_value;
                  end
                  if (state.param_count < tkd_pkg::ParamCountMax) begin
                     state_next.param_count = state.param_count + 2'd1;
                  end
               end
            end
            default: begin
               if (byte_value[7:6] != 2'b10) begin
                  // broken sequence: drop it and take the byte afresh
                  state_next.mode          = tkd_pkg::ModeGround;
                  state_next.utf8_gathered = '0;
                  state_next.utf8_expected = '0;
                  state_next.utf8_count    = '0;
                  run_ground               = 1'b1;
               end else if (cnt_inc >= state.utf8_expected) begin
                  emit_main                = 1'b1;
                  main_res.key             = tkd_pkg::KeyChar;
                  main_res.text_bytes      = utf8_text;
                  main_res.text_length     = cnt_inc;
                  state_next.mode          = tkd_pkg::ModeGround;
                  state_next.utf8_gathered = '0;
                  state_next.utf8_expected = '0;
                  state_next.utf8_count    = '0;
               end else begin
                  state_next.utf8_gathered = utf8_text[23:0];
                  state_next.utf8_count    = cnt_inc;
               end
            end
         endcase
      end

      // shared ground path
      if (run_ground) begin
         emit_main            = g.emit;
         main_res.key         = g.key;
         main_res.text_bytes  = {24'd0, g.text};
         main_res.text_length = g.len;
         if (g.go_escape) begin
            state_next.mode = tkd_pkg::ModeEscape;
         end
         if (g.go_utf8) begin
            state_next.mode          = tkd_pkg::ModeUtf8;
            state_next.utf8_gathered = {16'd0, byte_value};
            state_next.utf8_expected = g.lead_len;
            state_next.utf8_count    = 3'd1;
         end
      end
   end

   // pack results in order, last marks the final one
   always_comb begin
      push            = '0;
      push.count      = {1'b0, emit_esc} + {1'b0, emit_main};
      push.res_second = main_res;
      push.res_first  = emit_esc ? esc_res : main_res;
      if (emit_esc && emit_main) begin
         push.res_second.last = 1'b1;
      end else begin
         push.res_first.last = 1'b1;
      end
   end

endmodule

>>> sv/tkd_out_queue.sv
// result queue taking up to two results per cycle, giving one whenever rsp_if is ready
module tkd_out_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  tkd_pkg::tkd_push_type         push,
   tkd_rsp_if.source                     rsp_if,
   output tkd_pkg::tkd_queue_status_type status
);

   localparam int PtrBits = tkd_pkg::QueuePtrBits;
   localparam int CntBits = tkd_pkg::QueueCntBits;

   tkd_pkg::tkd_result_type entry_ff [tkd_pkg::QueueDepth];
   logic [PtrBits-1:0]      wr_ptr_ff;
   logic [PtrBits-1:0]      wr_ptr_in;
   logic [PtrBits-1:0]      rd_ptr_ff;
   logic [PtrBits-1:0]      rd_ptr_in;
   logic [CntBits-1:0]      count_ff;
   logic [CntBits-1:0]      count_in;
   logic [PtrBits-1:0]      wr_ptr_next;
   logic                    pop;

   // head of queue drives the result channel
   assign rsp_if.valid       = (count_ff != '0);
   assign rsp_if.key         = entry_ff[rd_ptr_ff].key;
   assign rsp_if.text_bytes  = entry_ff[rd_ptr_ff].text_bytes;
   assign rsp_if.text_length = entry_ff[rd_ptr_ff].text_length;
   assign rsp_if.last        = entry_ff[rd_ptr_ff].last;

   assign pop         = rsp_if.valid && rsp_if.ready;
   assign wr_ptr_next = wr_ptr_ff + PtrBits'(1);

   assign status.count    = count_ff;
   assign status.has_room =
      (count_ff <= CntBits'(tkd_pkg::QueueDepth - tkd_pkg::QueueRoomNeeded));

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff + PtrBits'(push.count);
      rd_ptr_in = rd_ptr_ff + PtrBits'(pop);
      count_in  = count_ff + CntBits'(push.count) - CntBits'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry writes, no reset on payload
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.res_first;
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_ptr_next] <= push.res_second;
      end
   end

endmodule

>>> sv/terminal_key_decoder_core.sv
// terminal key decoder: control bytes, lone esc, csi sequences and utf8 to key events
// an item waits in the input stage, then is decoded into the result queue feeding rsp_if
// throughput: one item per cycle while each item gives at most one result and rsp_if drains;
// an item that gives two results (esc then a byte) queues both for rsp_if in order
// reset: synchronous, active high; clears the decoder state to ground, the input stage
// and the four-entry result queue
module terminal_key_decoder_core (
   input  logic      clock,
   input  logic      reset,
   tkd_req_if.sink   req_if,
   tkd_rsp_if.source rsp_if
);

   logic                          in_valid_ff;
   logic                          in_valid_in;
   logic                          in_kind_ff;
   logic [7:0]                    in_byte_ff;
   logic                          fire;
   tkd_pkg::tkd_state_type        state_ff;
   tkd_pkg::tkd_state_type        state_in;
   tkd_pkg::tkd_state_type        state_next;
   tkd_pkg::tkd_push_type         dec_push;
   tkd_pkg::tkd_push_type         push;
   tkd_pkg::tkd_queue_status_type q_status;

   // decode the held item once the queue has room for two results
   assign fire         = in_valid_ff && q_status.has_room;
   assign req_if.ready = !in_valid_ff || fire;

   always_comb begin
      in_valid_in = (req_if.valid && req_if.ready) || (in_valid_ff && !fire);
      state_in    = fire ? state_next : state_ff;
      push        = fire ? dec_push : '0;
   end

   // input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         in_kind_ff <= req_if.kind;
         in_byte_ff <= req_if.byte_value;
      end
   end

   // decoder state, all zeros is ground mode with empty bookkeeping
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else begin
         state_ff <= state_in;
      end
   end

   tkd_decode u_decode (
      .state      (state_ff),
      .kind       (in_kind_ff),
      .byte_value (in_byte_ff),
      .state_next (state_next),
      .push       (dec_push)
   );

   tkd_out_queue u_out_queue (
      .clock  (clock),
      .reset  (reset),
      .push   (push),
      .rsp_if (rsp_if),
      .status (q_status)
   );

`ifndef SYNTHESIS
   // the queue never overfills
   assert property (@(posedge clock) disable iff (reset)
      q_status.count <= tkd_pkg::QueueCntBits'(tkd_pkg::QueueDepth))
      else $error("result queue overflow");

   // utf8 bookkeeping is clear whenever no utf8 sequence is open
   assert property (@(posedge clock) disable iff (reset)
      (state_ff.mode != tkd_pkg::ModeUtf8) |->
         (state_ff.utf8_count == '0 && state_ff.utf8_expected == '0))
      else $error("stale utf8 state outside utf8 mode");

   // an open utf8 sequence has gathered at least one byte and is not yet complete
   assert property (@(posedge clock) disable iff (reset)
      (state_ff.mode == tkd_pkg::ModeUtf8) |->
         (state_ff.utf8_count != '0 && state_ff.utf8_count < state_ff.utf8_expected))
      else $error("utf8 gather count out of range");

   // a held item that cannot be decoded keeps the decoder state unchanged
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !q_status.has_room) |=> $stable(state_ff))
      else $error("decoder state moved while stalled");
`endif

endmodule
